>>> hdl/ols_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg
// Shared constants, codes and beat structures of the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths of the request and response beats
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int LEN_W    = 7;
   localparam int OCNT_W   = 7;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      REQ_CLEAR      = 3'd0,
      REQ_APPEND     = 3'd1,
      REQ_INSERT     = 3'd2,
      REQ_REMOVE_AT  = 3'd3,
      REQ_REMOVE_ALL = 3'd4,
      REQ_SEARCH     = 3'd5,
      REQ_COUNT      = 3'd6,
      REQ_RETRIEVE   = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_POS  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef struct packed {
      req_code_type           kind;
      logic [POS_W-1:0]       position;
      logic signed [VAL_W-1:0] value;
      logic                   group_first;
      logic [LEN_W-1:0]       group_length;
   } ols_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  result_value;
      logic signed [OCNT_W-1:0] result_index;
      logic [OCNT_W-1:0]        match_count;
      logic [OCNT_W-1:0]        fill_level;
      logic                     list_full;
      logic                     list_empty;
      status_type               status;
   } ols_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  data;
   } ols_wr_type;

endpackage : ols_pkg
`default_nettype wire

>>> hdl/ordered_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of signed 32-bit words kept in a single entry RAM.
//   req_* : one request beat per operation; req_tuser selects the operation
//           (clear, append, insert, remove at, remove all, search, count,
//           retrieve) and flags the first beat of an append group.
//   rsp_* : one response beat per request, in order: retrieved/removed word,
//           search index, match count, size, full/empty flags and status.
// Operation (N = list size):
//   clear, append, rejected requests : answered straight from idle
//   insert / remove at position P    : walk entries P to N - 1, then finish
//   search, count, remove all        : sweep all N entries; retrieve : one read
//   One request in work at a time, one RAM entry read per cycle; worst case
//   is a full sweep of all CAPACITY entries.
// Reset: list empty, open append group dropped; RAM is not cleared, entries
//   beyond the size are never read.
// Backpressure: a stalled response is held in the output register while the
//   next request is worked up to its own response; then req_tready stays low.
// ----------------------------------------------------------------------------
module ordered_list_store
   import ols_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [6:0] position, [38:7] value, [45:39] group_length, [47:46] zero
   input  wire logic [47:0] req_tdata,
   // [2:0] req_type, [3] group_first
   input  wire logic [3:0]  req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] result_value, [38:32] result_index, [45:39] match_count,
   // [52:46] size, [53] list_full, [54] list_empty, [56:55] status,
   // [63:57] zero
   output logic [63:0]      rsp_tdata
);

   ols_req_type       req;
   ols_rsp_type       res;
   logic              res_valid;
   logic              res_ready;
   ols_wr_type        mem_wr;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [VAL_W-1:0]  mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   ols_rsp_type       rsp_ff;

   // unpack the request beat
   assign req.kind         = req_code_type'(req_tuser[2:0]);
   assign req.group_first  = req_tuser[3];
   assign req.position     = req_tdata[6:0];
   assign req.value        = req_tdata[38:7];
   assign req.group_length = req_tdata[45:39];

   ols_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ols_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr      (mem_wr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.status,
                        rsp_ff.list_empty,
                        rsp_ff.list_full,
                        rsp_ff.fill_level,
                        rsp_ff.match_count,
                        rsp_ff.result_index,
                        rsp_ff.result_value};

endmodule : ordered_list_store
`default_nettype wire

>>> hdl/ols_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ols_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : ols_ram
`default_nettype wire

>>> hdl/ols_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_ctrl
// Request sequencer: decodes a request, walks the entry RAM through a registered
// read, writes shifted or compacted entries back, builds the result.
// ----------------------------------------------------------------------------
module ols_ctrl
   import ols_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ols_req_type       req,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output ols_rsp_type            res,
   output ols_wr_type             mem_wr,
   output logic                   mem_rd_en,
   output logic [ADDR_W-1:0]      mem_rd_addr,
   input  wire logic [VAL_W-1:0]  mem_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_DONE
   } state_type;

   state_type         state_ff,    state_in;
   req_code_type      kind_ff,     kind_in;
   logic [ADDR_W-1:0] pos_ff,      pos_in;
   logic [VAL_W-1:0]  val_ff,      val_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic              group_ok_ff, group_ok_in;
   logic [CNT_W-1:0]  rem_ff,      rem_in;
   logic [ADDR_W-1:0] rd_addr_ff,  rd_addr_in;
   logic              down_ff,     down_in;
   logic              p_valid_ff,  p_valid_in;
   logic [ADDR_W-1:0] p_addr_ff,   p_addr_in;
   logic [CNT_W-1:0]  wr_ptr_ff,   wr_ptr_in;
   logic [CNT_W-1:0]  matches_ff,  matches_in;
   logic              found_ff,    found_in;
   logic [ADDR_W-1:0] idx_ff,      idx_in;
   logic [VAL_W-1:0]  rv_ff,       rv_in;
   status_type        status_ff,   status_in;

   logic [CMP_W-1:0]  pos_w;
   logic [CMP_W-1:0]  cnt_w;
   logic [CMP_W:0]    group_end;
   logic              hit;

   assign req_ready   = (state_ff == S_IDLE);
   assign res_valid   = (state_ff == S_DONE);
   assign mem_rd_addr = rd_addr_ff;
   assign hit         = (mem_rd_data == val_ff);

   assign pos_w     = CMP_W'(req.position);
   assign cnt_w     = CMP_W'(count_ff);
   assign group_end = (CMP_W+1)'(count_ff) + (CMP_W+1)'(req.group_length);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      count_in    = count_ff;
      group_ok_in = group_ok_ff;
      rem_in      = rem_ff;
      rd_addr_in  = rd_addr_ff;
      down_in     = down_ff;
      p_valid_in  = p_valid_ff;
      p_addr_in   = p_addr_ff;
      wr_ptr_in   = wr_ptr_ff;
      matches_in  = matches_ff;
      found_in    = found_ff;
      idx_in      = idx_ff;
      rv_in       = rv_ff;
      status_in   = status_ff;
      mem_wr      = '0;
      mem_rd_en   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = req.kind;
               pos_in     = ADDR_W'(req.position);
               val_in     = req.value;
               matches_in = '0;
               found_in   = 1'b0;
               idx_in     = '0;
               rv_in      = '0;
               wr_ptr_in  = '0;
               p_valid_in = 1'b0;
               status_in  = STAT_OK;
               down_in    = 1'b0;
               rd_addr_in = '0;
               rem_in     = count_ff;
               state_in   = S_DONE;
               case (req.kind)
                  REQ_CLEAR: begin
                     count_in    = '0;
                     group_ok_in = 1'b0;
                  end
                  REQ_APPEND: begin
                     if (req.group_first) begin
                        if ((req.group_length != '0) &&
                            (group_end <= (CMP_W+1)'(CAPACITY))) begin
                           mem_wr.en   = 1'b1;
                           mem_wr.addr = ADDR_W'(count_ff);
                           mem_wr.data = req.value;
                           count_in    = count_ff + 1'b1;
                           group_ok_in = 1'b1;
                        end else begin
                           group_ok_in = 1'b0;
                           status_in   = STAT_FULL;
                        end
                     end else if (group_ok_ff && (count_ff != CNT_W'(CAPACITY))) begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = ADDR_W'(count_ff);
                        mem_wr.data = req.value;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        status_in = STAT_FULL;
                     end
                  end
                  REQ_INSERT: begin
                     if (pos_w > cnt_w) begin
                        status_in = STAT_POS;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        // walk from the top entry down to the insert point
                        rem_in     = CNT_W'(cnt_w - pos_w);
                        rd_addr_in = ADDR_W'(count_ff - 1'b1);
                        down_in    = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  REQ_REMOVE_AT: begin
                     if (pos_w >= cnt_w) begin
                        status_in = STAT_POS;
                     end else begin
                        rem_in     = CNT_W'(cnt_w - pos_w);
                        rd_addr_in = ADDR_W'(req.position);
                        state_in   = S_SCAN;
                     end
                  end
                  REQ_RETRIEVE: begin
                     if (pos_w >= cnt_w) begin
                        status_in = STAT_POS;
                     end else begin
                        rem_in     = CNT_W'(1);
                        rd_addr_in = ADDR_W'(req.position);
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     // remove all, search, count: full sweep from entry 0
                     state_in = S_SCAN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (rem_ff != '0) begin
               mem_rd_en  = 1'b1;
               rem_in     = rem_ff - 1'b1;
               rd_addr_in = down_ff ? (rd_addr_ff - 1'b1) : (rd_addr_ff + 1'b1);
               p_valid_in = 1'b1;
               p_addr_in  = rd_addr_ff;
            end else begin
               p_valid_in = 1'b0;
               state_in   = S_FINISH;
            end

            // data read last cycle comes back now
            if (p_valid_ff) begin
               case (kind_ff)
                  REQ_INSERT: begin
                     mem_wr.en   = 1'b1;
                     mem_wr.addr = p_addr_ff + 1'b1;
                     mem_wr.data = mem_rd_data;
                  end
                  REQ_REMOVE_AT: begin
                     if (p_addr_ff == pos_ff) begin
                        rv_in = mem_rd_data;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = p_addr_ff - 1'b1;
                        mem_wr.data = mem_rd_data;
                     end
                  end
                  REQ_REMOVE_ALL: begin
                     if (hit) begin
                        matches_in = matches_ff + 1'b1;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = wr_ptr_ff[ADDR_W-1:0];
                        mem_wr.data = mem_rd_data;
                        wr_ptr_in   = wr_ptr_ff + 1'b1;
                     end
                  end
                  REQ_SEARCH: begin
                     if (hit && !found_ff) begin
                        found_in = 1'b1;
                        idx_in   = p_addr_ff;
                     end
                  end
                  REQ_COUNT: begin
                     if (hit) begin
                        matches_in = matches_ff + 1'b1;
                     end
                  end
                  REQ_RETRIEVE: begin
                     rv_in = mem_rd_data;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FINISH: begin
            case (kind_ff)
               REQ_INSERT: begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = pos_ff;
                  mem_wr.data = val_ff;
                  count_in    = count_ff + 1'b1;
               end
               REQ_REMOVE_AT: begin
                  count_in = count_ff - 1'b1;
               end
               REQ_REMOVE_ALL: begin
                  count_in = wr_ptr_ff;
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         group_ok_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         rem_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         group_ok_ff <= group_ok_in;
         p_valid_ff  <= p_valid_in;
         rem_ff      <= rem_in;
      end
      kind_ff    <= kind_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      rd_addr_ff <= rd_addr_in;
      down_ff    <= down_in;
      p_addr_ff  <= p_addr_in;
      wr_ptr_ff  <= wr_ptr_in;
      matches_ff <= matches_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
      rv_ff      <= rv_in;
      status_ff  <= status_in;
   end

   always_comb begin
      res.result_value = rv_ff;
      if (kind_ff == REQ_SEARCH) begin
         res.result_index = found_ff ? OCNT_W'(idx_ff) : '1;
      end else begin
         res.result_index = '0;
      end
      res.match_count = OCNT_W'(matches_ff);
      res.fill_level  = OCNT_W'(count_ff);
      res.list_full   = (count_ff == CNT_W'(CAPACITY));
      res.list_empty  = (count_ff == '0);
      res.status      = status_ff;
   end

endmodule : ols_ctrl
`default_nettype wire
